// File: sv/idh_pkg.sv
// shared types and constants for the interval domain with holes
package idh_pkg;

	localparam int SPAN   = 1024;
	localparam int AW     = $clog2(SPAN);
	localparam int CW     = AW + 1;
	localparam int KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		K_QUERY  = 3'd0,
		K_REMOVE = 3'd1,
		K_RAISE  = 3'd2,
		K_LOWER  = 3'd3,
		K_ASSIGN = 3'd4,
		K_TRUNC  = 3'd5,
		K_INIT   = 3'd6
	} kind_t;

	// operands of the shared adder
	typedef struct packed {
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		logic          sub;
	} alu_op_t;

	typedef struct packed {
		logic          ok;
		logic          member;
		logic [AW-1:0] lowest;
		logic [AW-1:0] highest;
		logic [CW-1:0] size;
		logic [CW-1:0] trail_depth;
	} res_t;

	typedef struct packed {
		logic ready;
		logic done;
	} eng_stat_t;

endpackage

// File: sv/idh_addsub.sv
// shared add/subtract unit used by the domain sequencer
module idh_addsub (
	input  idh_pkg::alu_op_t          op,
	output logic [idh_pkg::CW-1:0]    sum
);
	import idh_pkg::*;

	logic [CW-1:0] b_eff;

	assign b_eff = op.sub ? ~op.b : op.b;
	assign sum   = op.a + b_eff + CW'(op.sub);

endmodule

// File: sv/idh_engine.sv
// sequencer, hole map and removal trail of the interval domain
module idh_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [idh_pkg::KIND_W-1:0] kind,
	input  logic [idh_pkg::CW-1:0]     value,
	input  logic [idh_pkg::AW-1:0]     upper,
	input  logic [idh_pkg::CW-1:0]     count,
	input  logic                       slot_free,
	output idh_pkg::eng_stat_t         stat,
	output idh_pkg::res_t              res
);
	import idh_pkg::*;

	typedef enum logic [16:0] {
		S_RCLR  = 17'h00001,
		S_IDLE  = 17'h00002,
		S_DISP  = 17'h00004,
		S_LOOK  = 17'h00008,
		S_UPINC = 17'h00010,
		S_UPRD  = 17'h00020,
		S_UPEX  = 17'h00040,
		S_DNCHK = 17'h00080,
		S_DNRD  = 17'h00100,
		S_DNEX  = 17'h00200,
		S_CRD   = 17'h00400,
		S_CEX   = 17'h00800,
		S_CNT   = 17'h01000,
		S_TRD   = 17'h02000,
		S_TEX   = 17'h04000,
		S_ICLR  = 17'h08000,
		S_DONE  = 17'h10000
	} state_t;

	state_t        state_q, state_d;
	kind_t         rq_kind_q, rq_kind_d;
	logic [CW-1:0] rq_val_q, rq_val_d;
	logic [AW-1:0] rq_up_q, rq_up_d;
	logic [CW-1:0] rq_num_q, rq_num_d;
	logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [CW-1:0] cnt_q, cnt_d, tlen_q, tlen_d;
	logic [CW-1:0] w_q, w_d, i_q, i_d, kept_q, kept_d, in_q, in_d;
	logic          ok_q, ok_d, mem_q, mem_d;
	logic [AW-1:0] clr_q, clr_d;

	logic          hole_mem [SPAN];
	logic          hole_we, hole_wd, hole_rd_q;
	logic [AW-1:0] hole_wa, hole_ra;
	logic [AW-1:0] trail_mem [SPAN];
	logic          trail_we;
	logic [AW-1:0] trail_wa, trail_wd, trail_ra, trail_rd_q;

	alu_op_t       op;
	logic [CW-1:0] alu_sum;

	logic [CW-1:0] lo_x, hi_x, e_x;
	logic          indom, keep, in_span, is_raise;

	idh_addsub u_addsub (
		.op  (op),
		.sum (alu_sum)
	);

	assign lo_x     = {1'b0, lo_q};
	assign hi_x     = {1'b0, hi_q};
	assign e_x      = {1'b0, trail_rd_q};
	assign is_raise = (rq_kind_q == K_RAISE);
	assign indom    = (cnt_q != '0) && (rq_val_q >= lo_x) && (rq_val_q <= hi_x) && !hole_rd_q;
	assign keep     = is_raise ? (e_x >= rq_val_q) : (e_x <= rq_val_q);
	assign in_span  = is_raise ? (trail_rd_q <= hi_q) : (trail_rd_q >= lo_q);

	always_comb begin
		state_d   = state_q;
		rq_kind_d = rq_kind_q;
		rq_val_d  = rq_val_q;
		rq_up_d   = rq_up_q;
		rq_num_d  = rq_num_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		cnt_d     = cnt_q;
		tlen_d    = tlen_q;
		w_d       = w_q;
		i_d       = i_q;
		kept_d    = kept_q;
		in_d      = in_q;
		ok_d      = ok_q;
		mem_d     = mem_q;
		clr_d     = clr_q;
		hole_we   = 1'b0;
		hole_wa   = w_q[AW-1:0];
		hole_wd   = 1'b0;
		hole_ra   = w_q[AW-1:0];
		trail_we  = 1'b0;
		trail_wa  = kept_q[AW-1:0];
		trail_wd  = trail_rd_q;
		trail_ra  = i_q[AW-1:0];
		op        = '{a: w_q, b: CW'(1), sub: 1'b0};

		case (state_q)
			S_RCLR: begin
				hole_we = 1'b1;
				hole_wa = clr_q;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(SPAN - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					rq_kind_d = kind_t'(kind);
					rq_val_d  = value;
					rq_up_d   = upper;
					rq_num_d  = count;
					ok_d      = 1'b0;
					mem_d     = 1'b0;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (rq_kind_q)
					K_QUERY, K_REMOVE, K_ASSIGN: begin
						hole_ra = rq_val_q[AW-1:0];
						state_d = S_LOOK;
					end
					K_RAISE: begin
						i_d    = '0;
						kept_d = '0;
						in_d   = '1;
						if (cnt_q == '0) begin
							state_d = S_DONE;
						end else if (rq_val_q <= lo_x) begin
							ok_d    = 1'b1;
							state_d = S_DONE;
						end else if (rq_val_q > hi_x) begin
							state_d = S_DONE;
						end else begin
							state_d = S_CRD;
						end
					end
					K_LOWER: begin
						i_d    = '0;
						kept_d = '0;
						in_d   = '1;
						if (cnt_q == '0) begin
							state_d = S_DONE;
						end else if (rq_val_q >= hi_x) begin
							ok_d    = 1'b1;
							state_d = S_DONE;
						end else if (rq_val_q < lo_x) begin
							state_d = S_DONE;
						end else begin
							state_d = S_CRD;
						end
					end
					K_TRUNC: begin
						i_d     = rq_num_q;
						state_d = S_TRD;
					end
					K_INIT: begin
						tlen_d = '0;
						clr_d  = '0;
						op     = '{a: {1'b0, rq_up_q}, b: rq_val_q, sub: 1'b1};
						w_d    = alu_sum;
						if (rq_val_q <= {1'b0, rq_up_q}) begin
							lo_d = rq_val_q[AW-1:0];
							hi_d = rq_up_q;
							ok_d = 1'b1;
						end else begin
							lo_d  = '0;
							hi_d  = '0;
							cnt_d = '0;
						end
						state_d = S_ICLR;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_ICLR: begin
				hole_we = 1'b1;
				hole_wa = clr_q;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(SPAN - 1)) begin
					// size is upper - lower + 1
					if (ok_q) begin
						op    = '{a: w_q, b: CW'(1), sub: 1'b0};
						cnt_d = alu_sum;
					end
					state_d = S_DONE;
				end
			end
			S_LOOK: begin
				state_d = S_DONE;
				case (rq_kind_q)
					K_QUERY: begin
						ok_d  = 1'b1;
						mem_d = indom;
					end
					K_ASSIGN: begin
						if (indom) begin
							lo_d  = rq_val_q[AW-1:0];
							hi_d  = rq_val_q[AW-1:0];
							cnt_d = CW'(1);
							ok_d  = 1'b1;
						end
					end
					K_REMOVE: begin
						if (cnt_q == '0) begin
							ok_d = 1'b0;
						end else if (!indom) begin
							ok_d = 1'b1;
						end else if (cnt_q == CW'(1)) begin
							ok_d = 1'b0;
						end else begin
							if (tlen_q < CW'(SPAN)) begin
								trail_we = 1'b1;
								trail_wa = tlen_q[AW-1:0];
								trail_wd = rq_val_q[AW-1:0];
								tlen_d   = tlen_q + CW'(1);
							end
							hole_we = 1'b1;
							hole_wa = rq_val_q[AW-1:0];
							hole_wd = 1'b1;
							op      = '{a: cnt_q, b: CW'(1), sub: 1'b1};
							cnt_d   = alu_sum;
							w_d     = rq_val_q;
							if (rq_val_q == lo_x) begin
								state_d = S_UPINC;
							end else if (rq_val_q == hi_x) begin
								state_d = S_DNCHK;
							end else begin
								ok_d = 1'b1;
							end
						end
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			S_UPINC: begin
				op      = '{a: w_q, b: CW'(1), sub: 1'b0};
				w_d     = alu_sum;
				state_d = S_UPRD;
			end
			S_UPRD: begin
				if (w_q > hi_x) begin
					// only holes left between the scan start and the upper bound
					cnt_d = '0;
					ok_d  = 1'b0;
					if (is_raise) begin
						lo_d = rq_val_q[AW-1:0];
					end
					state_d = S_DONE;
				end else begin
					hole_ra = w_q[AW-1:0];
					state_d = S_UPEX;
				end
			end
			S_UPEX: begin
				if (hole_rd_q) begin
					op      = '{a: w_q, b: CW'(1), sub: 1'b0};
					w_d     = alu_sum;
					state_d = S_UPRD;
				end else begin
					lo_d = w_q[AW-1:0];
					if ((rq_kind_q == K_REMOVE) && (rq_val_q == hi_x)) begin
						state_d = S_DNCHK;
					end else begin
						ok_d    = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_DNCHK: begin
				if (hi_q <= lo_q) begin
					cnt_d   = '0;
					ok_d    = 1'b0;
					state_d = S_DONE;
				end else begin
					op      = '{a: hi_x, b: CW'(1), sub: 1'b1};
					w_d     = alu_sum;
					state_d = S_DNRD;
				end
			end
			S_DNRD: begin
				hole_ra = w_q[AW-1:0];
				state_d = S_DNEX;
			end
			S_DNEX: begin
				if (hole_rd_q && (w_q > lo_x)) begin
					op      = '{a: w_q, b: CW'(1), sub: 1'b1};
					w_d     = alu_sum;
					state_d = S_DNRD;
				end else if (hole_rd_q) begin
					cnt_d = '0;
					ok_d  = 1'b0;
					if (rq_kind_q == K_LOWER) begin
						hi_d = rq_val_q[AW-1:0];
					end
					state_d = S_DONE;
				end else begin
					hi_d    = w_q[AW-1:0];
					ok_d    = 1'b1;
					state_d = S_DONE;
				end
			end
			S_CRD: begin
				if (i_q < tlen_q) begin
					trail_ra = i_q[AW-1:0];
					state_d  = S_CEX;
				end else begin
					tlen_d = kept_q;
					if (is_raise) begin
						op = '{a: hi_x, b: rq_val_q, sub: 1'b1};
					end else begin
						op = '{a: rq_val_q, b: lo_x, sub: 1'b1};
					end
					w_d     = alu_sum;
					state_d = S_CNT;
				end
			end
			S_CEX: begin
				if (keep) begin
					trail_we = 1'b1;
					trail_wa = kept_q[AW-1:0];
					trail_wd = trail_rd_q;
					kept_d   = kept_q + CW'(1);
					if (in_span) begin
						in_d = in_q + CW'(1);
					end
				end else begin
					hole_we = 1'b1;
					hole_wa = trail_rd_q;
					hole_wd = 1'b0;
				end
				i_d     = i_q + CW'(1);
				state_d = S_CRD;
			end
			S_CNT: begin
				// in_q counts kept entries inside the new bounds minus one
				op      = '{a: w_q, b: in_q, sub: 1'b1};
				cnt_d   = alu_sum;
				w_d     = rq_val_q;
				state_d = is_raise ? S_UPRD : S_DNRD;
			end
			S_TRD: begin
				if (i_q < tlen_q) begin
					trail_ra = i_q[AW-1:0];
					state_d  = S_TEX;
				end else begin
					if (rq_num_q < tlen_q) begin
						tlen_d = rq_num_q;
					end
					ok_d    = 1'b1;
					state_d = S_DONE;
				end
			end
			S_TEX: begin
				hole_we = 1'b1;
				hole_wa = trail_rd_q;
				hole_wd = 1'b0;
				i_d     = i_q + CW'(1);
				state_d = S_TRD;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RCLR;
			lo_q    <= '0;
			hi_q    <= '0;
			cnt_q   <= '0;
			tlen_q  <= '0;
			clr_q   <= '0;
			ok_q    <= 1'b0;
			mem_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			cnt_q   <= cnt_d;
			tlen_q  <= tlen_d;
			clr_q   <= clr_d;
			ok_q    <= ok_d;
			mem_q   <= mem_d;
		end
	end

	always_ff @(posedge clk) begin
		rq_kind_q <= rq_kind_d;
		rq_val_q  <= rq_val_d;
		rq_up_q   <= rq_up_d;
		rq_num_q  <= rq_num_d;
		w_q       <= w_d;
		i_q       <= i_d;
		kept_q    <= kept_d;
		in_q      <= in_d;
	end

	always_ff @(posedge clk) begin
		if (hole_we) begin
			hole_mem[hole_wa] <= hole_wd;
		end
		hole_rd_q <= hole_mem[hole_ra];
	end

	always_ff @(posedge clk) begin
		if (trail_we) begin
			trail_mem[trail_wa] <= trail_wd;
		end
		trail_rd_q <= trail_mem[trail_ra];
	end

	assign stat.ready      = (state_q == S_IDLE);
	assign stat.done       = (state_q == S_DONE);
	assign res.ok          = ok_q;
	assign res.member      = mem_q;
	assign res.lowest      = lo_q;
	assign res.highest     = hi_q;
	assign res.size        = cnt_q;
	assign res.trail_depth = tlen_q;

endmodule

// File: sv/interval_domain_with_holes_core.sv
// top level of the interval domain with holes: request intake and result register
//
//   channel  | handshake            | payload
//   request  | req_valid, req_stall | kind, value, upper, count
//   result   | res_valid, res_stall | ok, member, lowest, highest, size, trail_depth
//
// one request at a time; a remove also steps past the holes beside each bound it moves, a bound
// cut walks the whole trail and then steps past holes, a truncate visits each dropped entry, an
// init sweeps the whole hole map
// after reset the hole map is swept with req_stall high
// the next request is taken while a result waits in the output register
module interval_domain_with_holes_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [idh_pkg::KIND_W-1:0] kind,
	input  logic [idh_pkg::CW-1:0]     value,
	input  logic [idh_pkg::AW-1:0]     upper,
	input  logic [idh_pkg::CW-1:0]     count,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       ok,
	output logic                       member,
	output logic [idh_pkg::AW-1:0]     lowest,
	output logic [idh_pkg::AW-1:0]     highest,
	output logic [idh_pkg::CW-1:0]     size,
	output logic [idh_pkg::CW-1:0]     trail_depth
);
	import idh_pkg::*;

	eng_stat_t stat;
	res_t      eng_res;
	res_t      res_q;
	logic      res_valid_q;
	logic      slot_free;
	logic      start;

	assign req_stall = !stat.ready;
	assign start     = req_valid && !req_stall;
	assign slot_free = !res_valid_q || !res_stall;

	idh_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.value     (value),
		.upper     (upper),
		.count     (count),
		.slot_free (slot_free),
		.stat      (stat),
		.res       (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.done && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && slot_free) begin
			res_q <= eng_res;
		end
	end

	assign res_valid   = res_valid_q;
	assign ok          = res_q.ok;
	assign member      = res_q.member;
	assign lowest      = res_q.lowest;
	assign highest     = res_q.highest;
	assign size        = res_q.size;
	assign trail_depth = res_q.trail_depth;

endmodule

// File: tb/sv/idh_checker.sv
// checker for the interval domain: watches both channels, predicts each result and compares
`timescale 1ns / 100ps

module idh_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic [idh_pkg::KIND_W-1:0] req_kind,
	input  logic [idh_pkg::CW-1:0]     req_value,
	input  logic [idh_pkg::AW-1:0]     req_upper,
	input  logic [idh_pkg::CW-1:0]     req_count,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  logic                       res_ok,
	input  logic                       res_member,
	input  logic [idh_pkg::AW-1:0]     res_lowest,
	input  logic [idh_pkg::AW-1:0]     res_highest,
	input  logic [idh_pkg::CW-1:0]     res_size,
	input  logic [idh_pkg::CW-1:0]     res_depth,
	output int unsigned                n_fails,
	output int unsigned                n_pending,
	output int unsigned                n_checked,
	output int unsigned                n_rejects,
	output int unsigned                n_members,
	output int unsigned                deepest
);
	import idh_pkg::*;

	// shadow of the domain
	logic [SPAN-1:0] holes = '0;
	logic [AW-1:0]   trail [SPAN];
	int              lo_b = 0;
	int              hi_b = 0;
	int              live = 0;
	int              tlen = 0;

	res_t        expected_q [$];
	res_t        want;
	int unsigned fail_count = 0;
	int unsigned checked_count = 0;
	int unsigned reject_count = 0;
	int unsigned member_count = 0;
	int unsigned max_depth = 0;

	initial begin
		n_fails   = 0;
		n_pending = 0;
		n_checked = 0;
		n_rejects = 0;
		n_members = 0;
		deepest   = 0;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val)
			report($sformatf("result %0d field %s expected %0d got %0d",
				checked_count, name, exp_val, got_val));
	endtask

	function automatic bit in_domain(int v);
		if (live == 0 || v < lo_b || v > hi_b || v >= SPAN)
			return 1'b0;
		return !holes[v];
	endfunction

	function automatic bit drop_value(int v);
		int w;
		if (!in_domain(v))
			return 1'b1;
		if (live == 1)
			return 1'b0;
		if (tlen < SPAN) begin
			trail[tlen] = v[AW-1:0];
			tlen++;
		end
		holes[v] = 1'b1;
		live--;
		if (v == lo_b) begin
			w = v + 1;
			while (w <= hi_b && holes[w])
				w++;
			if (w > hi_b) begin
				live = 0;
				return 1'b0;
			end
			lo_b = w;
		end
		if (v == hi_b) begin
			if (hi_b <= lo_b) begin
				live = 0;
				return 1'b0;
			end
			w = hi_b - 1;
			while (w > lo_b && holes[w])
				w--;
			if (holes[w]) begin
				live = 0;
				return 1'b0;
			end
			hi_b = w;
		end
		return 1'b1;
	endfunction

	// keep trail entries in [keep_lo, keep_hi], free the rest; count kept ones in [in_lo, in_hi]
	function automatic int compact_trail(int keep_lo, int keep_hi, int in_lo, int in_hi);
		int kept;
		int hits;
		int e;
		kept = 0;
		hits = 0;
		for (int i = 0; i < tlen; i++) begin
			e = trail[i];
			if (e >= keep_lo && e <= keep_hi) begin
				trail[kept] = e[AW-1:0];
				kept++;
				if (e >= in_lo && e <= in_hi)
					hits++;
			end else begin
				holes[e] = 1'b0;
			end
		end
		tlen = kept;
		return hits;
	endfunction

	function automatic bit raise_low(int t);
		int hits;
		int w;
		if (t <= lo_b)
			return 1'b1;
		if (t > hi_b)
			return 1'b0;
		hits = compact_trail(t, SPAN - 1, t, hi_b);
		live = hi_b - t + 1 - hits;
		w    = t;
		while (w <= hi_b && holes[w])
			w++;
		if (w > hi_b) begin
			lo_b = t;
			live = 0;
			return 1'b0;
		end
		lo_b = w;
		return 1'b1;
	endfunction

	function automatic bit lower_high(int t);
		int hits;
		int w;
		if (t >= hi_b)
			return 1'b1;
		if (t < lo_b)
			return 1'b0;
		hits = compact_trail(0, t, lo_b, t);
		live = t - lo_b + 1 - hits;
		w    = t;
		while (w > lo_b && holes[w])
			w--;
		if (holes[w]) begin
			hi_b = t;
			live = 0;
			return 1'b0;
		end
		hi_b = w;
		return 1'b1;
	endfunction

	function automatic res_t apply_request(logic [KIND_W-1:0] k, int v, int u, int c);
		res_t r;
		r = '0;
		case (k)
			K_QUERY: begin
				r.ok     = 1'b1;
				r.member = in_domain(v);
			end
			K_REMOVE: r.ok = (live != 0) && drop_value(v);
			K_RAISE:  r.ok = (live != 0) && raise_low(v);
			K_LOWER:  r.ok = (live != 0) && lower_high(v);
			K_ASSIGN: begin
				if (in_domain(v)) begin
					lo_b = v;
					hi_b = v;
					live = 1;
					r.ok = 1'b1;
				end
			end
			K_TRUNC: begin
				for (int i = c; i < tlen; i++)
					holes[trail[i]] = 1'b0;
				if (c < tlen)
					tlen = c;
				r.ok = 1'b1;
			end
			K_INIT: begin
				holes = '0;
				tlen  = 0;
				if (v <= u && u < SPAN) begin
					lo_b = v;
					hi_b = u;
					live = u - v + 1;
					r.ok = 1'b1;
				end else begin
					lo_b = 0;
					hi_b = 0;
					live = 0;
				end
			end
			default: ;
		endcase
		r.lowest      = lo_b[AW-1:0];
		r.highest     = hi_b[AW-1:0];
		r.size        = live[CW-1:0];
		r.trail_depth = tlen[CW-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// results first: a result never belongs to a request taken at the same edge
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					report("result arrived with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("ok", want.ok, res_ok);
					check_field("member", want.member, res_member);
					check_field("lowest", want.lowest, res_lowest);
					check_field("highest", want.highest, res_highest);
					check_field("size", want.size, res_size);
					check_field("trail_depth", want.trail_depth, res_depth);
					checked_count++;
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_request(req_kind, req_value, req_upper, req_count);
				expected_q = {expected_q, want};
				if (!want.ok)
					reject_count++;
				if (want.member)
					member_count++;
				if (tlen > max_depth)
					max_depth = tlen;
			end
			n_fails   <= fail_count;
			n_pending <= expected_q.size();
			n_checked <= checked_count;
			n_rejects <= reject_count;
			n_members <= member_count;
			deepest   <= max_depth;
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for the interval domain core: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
	import idh_pkg::*;

	localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;
	localparam int TARGET         = 1400;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN          = 64;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [KIND_W-1:0] kind;
	logic [CW-1:0]     value;
	logic [AW-1:0]     upper;
	logic [CW-1:0]     count;
	logic              res_valid;
	logic              res_stall;
	logic              ok;
	logic              member;
	logic [AW-1:0]     lowest;
	logic [AW-1:0]     highest;
	logic [CW-1:0]     size;
	logic [CW-1:0]     trail_depth;

	int unsigned n_fails;
	int unsigned n_pending;
	int unsigned n_checked;
	int unsigned n_rejects;
	int unsigned n_members;
	int unsigned deepest;

	int n_sent      = 0;
	int n_inits     = 0;
	int burst_left  = 0;
	int idle_cycles = 0;
	bit hold_req    = 1'b0;
	bit hold_done   = 1'b0;

	interval_domain_with_holes_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.value       (value),
		.upper       (upper),
		.count       (count),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.ok          (ok),
		.member      (member),
		.lowest      (lowest),
		.highest     (highest),
		.size        (size),
		.trail_depth (trail_depth)
	);

	idh_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_kind    (kind),
		.req_value   (value),
		.req_upper   (upper),
		.req_count   (count),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_ok      (ok),
		.res_member  (member),
		.res_lowest  (lowest),
		.res_highest (highest),
		.res_size    (size),
		.res_depth   (trail_depth),
		.n_fails     (n_fails),
		.n_pending   (n_pending),
		.n_checked   (n_checked),
		.n_rejects   (n_rejects),
		.n_members   (n_members),
		.deepest     (deepest)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender works in bursts; valid stays up across a burst
	task automatic offer(input logic [KIND_W-1:0] k, input int v, input int u, input int c);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 15) == 0)
				gap = $urandom_range(20, 60);
			else if ($urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		kind      <= k;
		value     <= v[CW-1:0];
		upper     <= u[AW-1:0];
		count     <= c[CW-1:0];
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (k != K_UNUSED)
			n_sent++;
		if (k == K_INIT)
			n_inits++;
		if (n_sent == HOLD_AT)
			hold_req <= 1'b1;
	endtask

	// one init followed by a run of requests, most aimed at the initial interval
	task automatic run_episode();
		int width;
		int lo;
		int hi;
		int ops;
		int pick;
		int v;
		int vmin;
		int vmax;
		int removed;
		int bad_lo;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			width = $urandom_range(1, 16);
		else if (pick < 9)
			width = $urandom_range(17, 200);
		else
			width = $urandom_range(200, SPAN);
		lo   = $urandom_range(0, SPAN - width);
		hi   = lo + width - 1;
		ops  = (width > 200) ? $urandom_range(60, 150) : $urandom_range(10, 40);
		vmin = (lo >= 2) ? lo - 2 : 0;
		vmax = (hi + 2 > SPAN) ? SPAN : hi + 2;
		offer(K_INIT, lo, hi, $urandom_range(0, SPAN));
		removed = 0;
		repeat (ops) begin
			pick = $urandom_range(0, 99);
			v    = $urandom_range(vmin, vmax);
			if (pick < 45) begin
				offer(K_REMOVE, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
				removed++;
			end else if (pick < 60) begin
				offer(K_QUERY, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else if (pick < 67) begin
				offer(K_RAISE, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else if (pick < 74) begin
				offer(K_LOWER, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else if (pick < 82) begin
				offer(K_TRUNC, v, $urandom_range(0, SPAN - 1), $urandom_range(0, removed + 1));
			end else if (pick < 86) begin
				offer(K_ASSIGN, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else if (pick < 89) begin
				offer(K_TRUNC, v, $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else if (pick < 93) begin
				offer(K_UNUSED, $urandom_range(0, SPAN), $urandom_range(0, SPAN - 1),
					$urandom_range(0, SPAN));
			end else if (pick < 98) begin
				// any kind from query to assign, value anywhere
				offer(kind_t'($urandom_range(K_QUERY, K_ASSIGN)), $urandom_range(0, SPAN),
					$urandom_range(0, SPAN - 1), $urandom_range(0, SPAN));
			end else begin
				// malformed init: lower bound above upper bound
				bad_lo = $urandom_range(1, SPAN);
				offer(K_INIT, bad_lo, $urandom_range(0, bad_lo - 1), $urandom_range(0, SPAN));
			end
		end
	endtask

	initial begin
		req_valid <= 1'b0;
		kind      <= K_QUERY;
		value     <= '0;
		upper     <= '0;
		count     <= '0;
		arst_n    <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty domain after reset
		offer(K_QUERY, 5, 0, 0);
		offer(K_REMOVE, 5, 0, 0);
		offer(K_RAISE, 5, 0, 0);
		offer(K_LOWER, 5, 0, 0);
		offer(K_ASSIGN, 0, 0, 0);
		offer(K_TRUNC, 0, 0, 0);
		offer(K_UNUSED, 3, 1, 1);
		// rejected inits
		offer(K_INIT, 5, 3, 0);
		offer(K_INIT, SPAN, SPAN - 1, 0);
		// full span, then bound moves, holes and trail handling
		offer(K_INIT, 0, SPAN - 1, SPAN);
		offer(K_QUERY, SPAN, 0, 0);
		offer(K_REMOVE, 0, 0, 0);
		offer(K_REMOVE, SPAN - 1, 0, 0);
		offer(K_REMOVE, SPAN, 0, 0);
		offer(K_REMOVE, 0, 0, 0);
		offer(K_REMOVE, 500, 0, 0);
		offer(K_REMOVE, 500, 0, 0);
		offer(K_TRUNC, 0, SPAN - 1, SPAN);
		offer(K_TRUNC, 0, 0, 1);
		offer(K_RAISE, 600, 0, 0);
		offer(K_RAISE, 100, 0, 0);
		offer(K_LOWER, 599, 0, 0);
		offer(K_ASSIGN, 700, 0, 0);
		offer(K_REMOVE, 700, 0, 0);
		offer(K_ASSIGN, 701, 0, 0);

		while (n_sent < TARGET)
			run_episode();

		req_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d requests (%0d inits) with %0d results checked, %0d rejected",
			n_sent, n_inits, n_checked, n_rejects);
		$display("membership hits %0d, deepest removal trail %0d", n_members, deepest);
		if (n_fails == 0 && n_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// receiver stall pattern, plus one long hold-off to back the block up
	initial begin
		int mode;
		int span_len;
		int tick;
		tick = 0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode     = $urandom_range(0, 3);
			span_len = $urandom_range(20, 200);
			repeat (span_len) begin
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 9) < 3);
					2: res_stall <= ($urandom_range(0, 9) < 8);
					default: res_stall <= (tick % 3 == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// watchdog: too long without any request or result moving
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

endmodule
